[rtl/tsim_pkg.sv]
// Shared types and constants for the Tanimoto similarity block.
`default_nettype none

package tsim_pkg;

  localparam int ACC_W = 64;  // accumulator width, wraps modulo 2^64
  localparam int DIV_W = 66;  // divider datapath: sum of two norms, shifted once

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AB,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_ACC_BB,
    ST_DIV_SUM,
    ST_DIV_DEN,
    ST_DIV_CHK,
    ST_DIV_ITER,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic sub;   // 1: x - y, 0: x + y
    logic shl1;  // shift x left by one before the operation
  } alu_ctl_t;

endpackage

`default_nettype wire

[rtl/tsim_alu.sv]
// Shared wide add/subtract unit used for accumulation and restoring division.
`default_nettype none

module tsim_alu (
  input  tsim_pkg::alu_ctl_t             ctl,
  input  logic [tsim_pkg::DIV_W-1:0]     x,
  input  logic [tsim_pkg::DIV_W-1:0]     y,
  output logic [tsim_pkg::DIV_W-1:0]     res,
  output logic                           ge
);

  logic [tsim_pkg::DIV_W-1:0] x_op;
  logic [tsim_pkg::DIV_W:0]   full;

  always_comb begin
    x_op = ctl.shl1 ? {x[tsim_pkg::DIV_W-2:0], 1'b0} : x;
    if (ctl.sub) begin
      full = {1'b0, x_op} - {1'b0, y};
    end else begin
      full = {1'b0, x_op} + {1'b0, y};
    end
    res = full[tsim_pkg::DIV_W-1:0];
    // no borrow out means x_op >= y
    ge  = ~full[tsim_pkg::DIV_W];
  end

endmodule

`default_nettype wire

[rtl/tanimoto_similarity_u16.sv]
// Top level: streaming Tanimoto similarity of two unsigned vectors.
//
// Element pairs arrive on the slave side, one item per pair, tlast marking the
// final pair. The block takes no new pair until it is through with the last one: one shared
// ELEMENT_WIDTH x ELEMENT_WIDTH multiplier forms a*b, a*a and b*b in turn and
// one shared 66-bit add/subtract unit folds each product into its 64-bit
// wrapping sum. On the last pair the same add/subtract unit then runs a
// restoring division, one quotient bit per cycle; the division ends early
// when the result saturates to 1.0. The finished result is loaded into an
// output register, so the next vector can start while it waits to be taken;
// loading a new result waits only if the previous one is still held.
// Accumulators are cleared at load.
`default_nettype none

module tanimoto_similarity_u16 #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata fields from bit 0: a_value, b_value
  input  logic [((2*ELEMENT_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic s_tlast,  // last_element
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata fields from bit 0: similarity, dot_sum, norm_a_sum, norm_b_sum
  output logic [((FRACTION_BITS+1+3*tsim_pkg::ACC_W+7)/8)*8-1:0] m_tdata
);

  localparam int OUT_W  = ((FRACTION_BITS+1+3*tsim_pkg::ACC_W+7)/8)*8;
  localparam int PROD_W = 2*ELEMENT_WIDTH;
  localparam int SIM_W  = FRACTION_BITS+1;
  localparam int CNT_W  = $clog2(FRACTION_BITS);
  localparam int ACC_W  = tsim_pkg::ACC_W;
  localparam int DIV_W  = tsim_pkg::DIV_W;
  localparam logic [SIM_W-1:0] SIM_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRACTION_BITS-1);

  tsim_pkg::state_t state, state_next;

  logic [ELEMENT_WIDTH-1:0] a_reg, b_reg;
  logic                     last_reg;
  logic [ELEMENT_WIDTH-1:0] mul_x, mul_y;
  logic [PROD_W-1:0]        prod;
  logic [ACC_W-1:0]         dot_acc, na_acc, nb_acc;
  logic [DIV_W-1:0]         denom, rem;
  logic [FRACTION_BITS-1:0] quot;
  logic [CNT_W-1:0]         cnt;
  logic                     sat;
  logic                     out_load;
  logic                     in_take;

  logic [SIM_W-1:0]         out_sim;
  logic [ACC_W-1:0]         out_dot, out_na, out_nb;

  tsim_pkg::alu_ctl_t       alu_ctl;
  logic [DIV_W-1:0]         alu_x, alu_y, alu_res;
  logic                     alu_ge;
  logic                     den_sat;

  tsim_alu u_alu (
    .ctl (alu_ctl),
    .x   (alu_x),
    .y   (alu_y),
    .res (alu_res),
    .ge  (alu_ge)
  );

  // sum of norms not above dot: denominator is zero or negative
  assign den_sat = !alu_ge || (alu_res == '0);
  assign in_take = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tsim_pkg::ST_IDLE:     if (s_tvalid) state_next = tsim_pkg::ST_MUL_AB;
      tsim_pkg::ST_MUL_AB:   state_next = tsim_pkg::ST_MUL_AA;
      tsim_pkg::ST_MUL_AA:   state_next = tsim_pkg::ST_MUL_BB;
      tsim_pkg::ST_MUL_BB:   state_next = tsim_pkg::ST_ACC_BB;
      tsim_pkg::ST_ACC_BB: begin
        state_next = last_reg ? tsim_pkg::ST_DIV_SUM : tsim_pkg::ST_IDLE;
      end
      tsim_pkg::ST_DIV_SUM:  state_next = tsim_pkg::ST_DIV_DEN;
      tsim_pkg::ST_DIV_DEN: begin
        state_next = den_sat ? tsim_pkg::ST_OUT : tsim_pkg::ST_DIV_CHK;
      end
      tsim_pkg::ST_DIV_CHK: begin
        state_next = alu_ge ? tsim_pkg::ST_OUT : tsim_pkg::ST_DIV_ITER;
      end
      tsim_pkg::ST_DIV_ITER: if (cnt == CNT_LAST) state_next = tsim_pkg::ST_OUT;
      tsim_pkg::ST_OUT:      if (out_load) state_next = tsim_pkg::ST_IDLE;
      default:               state_next = tsim_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    s_tready     = 1'b0;
    out_load     = 1'b0;
    mul_x        = a_reg;
    mul_y        = b_reg;
    alu_ctl.sub  = 1'b0;
    alu_ctl.shl1 = 1'b0;
    alu_x        = '0;
    alu_y        = '0;
    case (state)
      tsim_pkg::ST_IDLE: s_tready = 1'b1;
      tsim_pkg::ST_MUL_AB: begin
        mul_x = a_reg;
        mul_y = b_reg;
      end
      tsim_pkg::ST_MUL_AA: begin
        mul_x = a_reg;
        mul_y = a_reg;
        alu_x = DIV_W'(dot_acc);
        alu_y = DIV_W'(prod);
      end
      tsim_pkg::ST_MUL_BB: begin
        mul_x = b_reg;
        mul_y = b_reg;
        alu_x = DIV_W'(na_acc);
        alu_y = DIV_W'(prod);
      end
      tsim_pkg::ST_ACC_BB: begin
        alu_x = DIV_W'(nb_acc);
        alu_y = DIV_W'(prod);
      end
      tsim_pkg::ST_DIV_SUM: begin
        alu_x = DIV_W'(na_acc);
        alu_y = DIV_W'(nb_acc);
      end
      tsim_pkg::ST_DIV_DEN: begin
        alu_ctl.sub = 1'b1;
        alu_x       = denom;
        alu_y       = DIV_W'(dot_acc);
      end
      tsim_pkg::ST_DIV_CHK: begin
        alu_ctl.sub = 1'b1;
        alu_x       = rem;
        alu_y       = denom;
      end
      tsim_pkg::ST_DIV_ITER: begin
        alu_ctl.sub  = 1'b1;
        alu_ctl.shl1 = 1'b1;
        alu_x        = rem;
        alu_y        = denom;
      end
      tsim_pkg::ST_OUT: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // control state and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tsim_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      dot_acc  <= '0;
      na_acc   <= '0;
      nb_acc   <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        tsim_pkg::ST_MUL_AA: dot_acc <= alu_res[ACC_W-1:0];
        tsim_pkg::ST_MUL_BB: na_acc  <= alu_res[ACC_W-1:0];
        tsim_pkg::ST_ACC_BB: nb_acc  <= alu_res[ACC_W-1:0];
        tsim_pkg::ST_OUT: begin
          if (out_load) begin
            dot_acc <= '0;
            na_acc  <= '0;
            nb_acc  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      tsim_pkg::ST_IDLE: begin
        if (in_take) begin
          a_reg    <= s_tdata[ELEMENT_WIDTH-1:0];
          b_reg    <= s_tdata[2*ELEMENT_WIDTH-1:ELEMENT_WIDTH];
          last_reg <= s_tlast;
        end
      end
      tsim_pkg::ST_MUL_AB, tsim_pkg::ST_MUL_AA, tsim_pkg::ST_MUL_BB: begin
        prod <= PROD_W'(mul_x) * PROD_W'(mul_y);
      end
      tsim_pkg::ST_DIV_SUM: begin
        denom <= alu_res;
        rem   <= DIV_W'(dot_acc);
        sat   <= 1'b0;
      end
      tsim_pkg::ST_DIV_DEN: begin
        denom <= alu_res;
        sat   <= den_sat;
      end
      tsim_pkg::ST_DIV_CHK: begin
        sat <= alu_ge;
        cnt <= '0;
      end
      tsim_pkg::ST_DIV_ITER: begin
        rem  <= alu_ge ? alu_res : {rem[DIV_W-2:0], 1'b0};
        quot <= {quot[FRACTION_BITS-2:0], alu_ge};
        cnt  <= cnt + 1'b1;
      end
      tsim_pkg::ST_OUT: begin
        if (out_load) begin
          out_sim <= sat ? SIM_ONE : {1'b0, quot};
          out_dot <= dot_acc;
          out_na  <= na_acc;
          out_nb  <= nb_acc;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = OUT_W'({out_nb, out_na, out_dot, out_sim});

`ifndef SYNTHESIS
  a_iter_rem_below_denom: assert property (@(posedge clk) disable iff (rst)
    (state == tsim_pkg::ST_DIV_ITER) |-> (rem < denom))
    else $error("partial remainder not below denominator");

  a_sim_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_sim <= SIM_ONE))
    else $error("similarity above one");

  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (dot_acc == '0 && na_acc == '0 && nb_acc == '0))
    else $error("accumulators not cleared after result load");

  a_plain_item_latency: assert property (@(posedge clk) disable iff (rst)
    (in_take && !s_tlast) |-> ##5 (state == tsim_pkg::ST_IDLE))
    else $error("non-last item did not return to idle");
`endif

endmodule

`default_nettype wire

[tb/sv/tanimoto_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the Tanimoto block: tracks the sums, predicts each vector's result, compares.

module tanimoto_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [31:0]  s_tdata,   // a_value, b_value
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [215:0] m_tdata,   // similarity, dot_sum, norm_a_sum, norm_b_sum
  output int           fails,
  output int           pending,
  output int           results,
  output int           saturated
);

  localparam int FRAC = 16;
  localparam logic [16:0] ONE = 17'd1 << FRAC;

  typedef struct packed {
    logic [16:0] sim;
    logic [63:0] dot;
    logic [63:0] na;
    logic [63:0] nb;
  } tanimoto_result_t;

  tanimoto_result_t expected_q[$];
  logic [63:0] dot_acc, na_acc, nb_acc;

  initial begin
    fails = 0;
    pending = 0;
    results = 0;
    saturated = 0;
  end

  // Exact restoring division on the wrapped sums, saturating at 1.0
  function automatic logic [16:0] tanimoto_q16(input logic [63:0] dot, na, nb);
    logic [65:0] total, denom, rem;
    logic [16:0] q;
    if (na == 64'd0 && nb == 64'd0) return ONE;
    total = {2'b00, na} + {2'b00, nb};
    if ({2'b00, dot} >= total) return ONE;
    denom = total - {2'b00, dot};
    rem = {2'b00, dot};
    if (rem >= denom) return ONE;
    q = '0;
    for (int i = 0; i < FRAC; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= denom) begin
        rem = rem - denom;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] want_v, got_v);
    if (fails < 10)
      $display("%0t mismatch in %s: expected %h, got %h", $realtime, field, want_v, got_v);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    tanimoto_result_t got, want;
    logic [63:0] a, b;
    if (rst) begin
      dot_acc <= '0;
      na_acc <= '0;
      nb_acc <= '0;
      expected_q.delete();
      pending <= 0;
    end else begin
      // take results first: a result never belongs to an item accepted at the same edge
      if (m_tvalid && m_tready) begin
        got = {m_tdata[16:0], m_tdata[80:17], m_tdata[144:81], m_tdata[208:145]};
        if (expected_q.size() == 0) begin
          note_mismatch("unexpected result", 64'd0, {47'd0, got.sim});
        end else begin
          want = expected_q.pop_front();
          results++;
          if (want.sim == ONE) saturated++;
          if (got.sim != want.sim) note_mismatch("similarity", 64'(want.sim), 64'(got.sim));
          if (got.dot != want.dot) note_mismatch("dot_sum", want.dot, got.dot);
          if (got.na != want.na) note_mismatch("norm_a_sum", want.na, got.na);
          if (got.nb != want.nb) note_mismatch("norm_b_sum", want.nb, got.nb);
        end
      end
      if (s_tvalid && s_tready) begin
        a = 64'(s_tdata[15:0]);
        b = 64'(s_tdata[31:16]);
        want.dot = dot_acc + a * b;
        want.na = na_acc + a * a;
        want.nb = nb_acc + b * b;
        if (s_tlast) begin
          want.sim = tanimoto_q16(want.dot, want.na, want.nb);
          expected_q.push_back(want);
          dot_acc <= '0;
          na_acc <= '0;
          nb_acc <= '0;
        end else begin
          dot_acc <= want.dot;
          na_acc <= want.na;
          nb_acc <= want.nb;
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for tanimoto_similarity_u16: clock, reset, pair stimulus and verdict.

module tb_top;

  localparam int NUM_PAIRS = 1350;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;  // a_value, b_value
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [((17 + 3 * tsim_pkg::ACC_W + 7) / 8) * 8 - 1:0] m_tdata;  // similarity, dot, norm_a, norm_b

  int fails, pending, results, saturated;
  int pairs_sent = 0;
  int vectors_sent = 0;
  logic calm = 1'b0;  // no idling on either side while set

  tanimoto_similarity_u16 dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  tanimoto_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fails(fails), .pending(pending), .results(results), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL tanimoto_similarity_u16");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 28);
  end

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
    if (!calm) begin
      while ($urandom_range(99) < 28) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, a};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pairs_sent++;
    if (last) vectors_sent++;
  endtask

  // hold the sender until every vector sent so far has produced its result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int len, kind;
    logic [15:0] a, b;
    logic paused;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero vector, equal max vectors, one side empty, bit patterns
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'hFFFF, 1'b1);
    send_pair(16'h0001, 16'h0002, 1'b0);
    send_pair(16'h0003, 16'h0004, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b1);
    send_pair(16'h0000, 16'h0005, 1'b0);
    send_pair(16'h0000, 16'h0007, 1'b1);
    send_pair(16'h1234, 16'h1234, 1'b0);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'hFFFF, 16'h0001, 1'b0);
    send_pair(16'h0001, 16'hFFFF, 1'b1);
    send_pair(16'h7FFF, 16'h8000, 1'b1);
    for (int k = 0; k < 8; k++) send_pair(16'hFFFF, 16'hFFFE, k == 7);
    drain();

    while (pairs_sent < NUM_PAIRS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 48) : $urandom_range(1, 6);
      kind = $urandom_range(4);
      calm = (vectors_sent >= 100 && vectors_sent < 150);
      if (!paused && pairs_sent >= 700) begin
        drain();
        paused = 1'b1;
      end
      for (int k = 0; k < len; k++) begin
        case (kind)
          0: begin
            a = 16'($urandom);
            b = 16'($urandom);
          end
          1: begin
            a = 16'($urandom_range(15));
            b = 16'($urandom_range(15));
          end
          2: begin
            a = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            b = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          end
          3: begin
            a = 16'($urandom);
            b = a;
          end
          default: begin
            a = 16'($urandom);
            b = $urandom_range(1) ? 16'h0000 : 16'($urandom);
          end
        endcase
        send_pair(a, b, k == len - 1);
      end
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Streamed %0d element pairs in %0d vectors, with stalls on both sides.",
             pairs_sent, vectors_sent);
    $display("Checked %0d results, %0d of them saturated at 1.0.", results, saturated);
    if (fails == 0) begin
      $display("PASS tanimoto_similarity_u16");
    end else begin
      $display("FAIL tanimoto_similarity_u16");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tsim_pkg.sv
rtl/tsim_alu.sv
rtl/tanimoto_similarity_u16.sv
tb/sv/tanimoto_checker.sv
tb/sv/tb_top.sv
